// ===== design/blkmv_pkg.sv =====
package blkmv_pkg;

  // Field and state widths
  localparam int SAMPLE_W = 24;
  localparam int LEN_W    = 16;
  localparam int CNT_W    = 16;
  localparam int ACC_W    = 40;
  localparam int MTOT_W   = 40;
  localparam int SQ_W     = 64;
  localparam int VAR_W    = 48;
  localparam int PROD_W   = 2 * SAMPLE_W;

  // Shared divider: one quotient bit per cycle over a DQ_W-bit dividend
  localparam int DQ_W   = 64;
  localparam int REM_W  = LEN_W;
  localparam int DCNT_W = 7;
  localparam logic [DCNT_W-1:0] DIV_STEPS_SHORT = DCNT_W'(ACC_W);
  localparam logic [DCNT_W-1:0] DIV_STEPS_LONG  = DCNT_W'(DQ_W);

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_BLOCK_LENGTH = 1'b0;  // selected by paddr[2]
  localparam logic [LEN_W-1:0] BLOCK_LENGTH_RESET = LEN_W'(1);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [SAMPLE_W-1:0] MEAN_POS_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] MEAN_NEG_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BDIV,
    ST_BSAT,
    ST_BMUL,
    ST_BACC,
    ST_FIN,
    ST_FDIVM,
    ST_FMEAN,
    ST_FDIVS,
    ST_FVAR,
    ST_FOUT
  } state_e;

endpackage

// ===== design/blocking_mean_variance.sv =====
// Blocking-method variance estimate. Samples (signed Q7.16) are summed into
// blocks of block_length samples (0 acts as 1); each full block's mean is the
// sum divided by block_length, truncated toward zero and saturated to the
// sample range. The beat marked last_sample closes the data set and yields
// one result beat: the mean of block means, their variance (mean of squares
// minus squared mean, clamped at zero, Q14.32), the block count (saturating
// at 65535 with count_overflow), the dropped trailing samples and no_blocks.
// All data-set state is then cleared; block_length is kept. A sample that
// completes no block is only accumulated; one that completes a block goes
// through the divider, then the saturate, square and accumulate steps; the
// last sample adds the divisions for the mean of means and the mean of
// squares plus bookkeeping, or only bookkeeping when no block is complete. The
// pace is set by one shared restoring divider that yields one quotient bit
// per cycle; in_stall_o is high whenever not idle. A finished result waits in
// an output register, so the next data set may start meanwhile.
module blocking_mean_variance
  import blkmv_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // sample channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       last_sample_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] mean_of_blocks_o,
  output logic        [VAR_W-1:0]    block_variance_o,
  output logic        [CNT_W-1:0]    full_blocks_o,
  output logic        [CNT_W-1:0]    dropped_count_o,
  output logic                       no_blocks_o,
  output logic                       count_overflow_o,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic        [PADDR_W-1:0]  paddr,
  input  logic        [PDATA_W-1:0]  pwdata,
  output logic        [PDATA_W-1:0]  prdata,
  output logic                       pready
);

  state_e state_q, state_d;

  logic [LEN_W-1:0]    len_q;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [CNT_W-1:0]    sib_q, sib_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [MTOT_W-1:0]   mtot_q, mtot_d;
  logic [SQ_W-1:0]     sq_q, sq_d;
  logic                ovf_q, ovf_d;
  logic                last_q, last_d;

  // shared divider
  logic [DQ_W-1:0]     dq_q, dq_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [LEN_W-1:0]    dvs_q, dvs_d;
  logic [DCNT_W-1:0]   dcnt_q, dcnt_d;
  logic                neg_q, neg_d;

  // mean and square datapath
  logic [SAMPLE_W-1:0] mean_q, mean_d;
  logic [SAMPLE_W-1:0] mag_q, mag_d;
  logic [PROD_W-1:0]   prod_q;
  logic [VAR_W-1:0]    var_q, var_d;

  // output register
  logic                ov_q, ov_d;
  logic [SAMPLE_W-1:0] o_mean_q;
  logic [VAR_W-1:0]    o_var_q;
  logic [CNT_W-1:0]    o_full_q;
  logic [CNT_W-1:0]    o_drop_q;
  logic                o_none_q;
  logic                o_ovf_q;
  logic                out_load;

  // combinational helpers
  logic [LEN_W-1:0]    len_eff;
  logic [ACC_W-1:0]    acc_new;
  logic [ACC_W-1:0]    acc_mag;
  logic [MTOT_W-1:0]   mtot_mag;
  logic [CNT_W-1:0]    sib_inc;
  logic                blk_done;
  logic [REM_W:0]      div_shift;
  logic                div_ge;
  logic [REM_W:0]      div_diff;
  logic [ACC_W-1:0]    quo_short;
  logic [SQ_W-1:0]     quo_long;
  logic                cfg_wr;

  // Configuration register
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BLOCK_LENGTH) ? PDATA_W'(len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= BLOCK_LENGTH_RESET;
    end else if (cfg_wr && paddr[2] == REG_BLOCK_LENGTH) begin
      len_q <= pwdata[LEN_W-1:0];
    end
  end

  // Per-sample arithmetic
  assign len_eff  = (len_q == '0) ? LEN_W'(1) : len_q;
  assign acc_new  = acc_q + {{(ACC_W-SAMPLE_W){sample_i[SAMPLE_W-1]}}, sample_i};
  assign acc_mag  = acc_new[ACC_W-1] ? (~acc_new + ACC_W'(1)) : acc_new;
  assign mtot_mag = mtot_q[MTOT_W-1] ? (~mtot_q + MTOT_W'(1)) : mtot_q;
  assign sib_inc  = (sib_q == CNT_MAX) ? sib_q : (sib_q + CNT_W'(1));
  assign blk_done = (sib_inc >= len_eff);

  // One restoring divider step
  assign div_shift = {rem_q, dq_q[DQ_W-1]};
  assign div_ge    = (div_shift >= {1'b0, dvs_q});
  assign div_diff  = div_shift - {1'b0, dvs_q};
  assign quo_short = dq_q[ACC_W-1:0];
  assign quo_long  = dq_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_load   = (state_q == ST_FOUT) && (!ov_q || !out_stall_i);

  // Next state and datapath control
  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    sib_d   = sib_q;
    cnt_d   = cnt_q;
    mtot_d  = mtot_q;
    sq_d    = sq_q;
    ovf_d   = ovf_q;
    last_d  = last_q;
    dq_d    = dq_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    dcnt_d  = dcnt_q;
    neg_d   = neg_q;
    mean_d  = mean_q;
    mag_d   = mag_q;
    var_d   = var_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          last_d = last_sample_i;
          if (blk_done) begin
            // hand the block sum to the divider
            acc_d   = '0;
            sib_d   = '0;
            dq_d    = {acc_mag, {(DQ_W-ACC_W){1'b0}}};
            rem_d   = '0;
            dvs_d   = len_eff;
            dcnt_d  = DIV_STEPS_SHORT;
            neg_d   = acc_new[ACC_W-1];
            state_d = ST_BDIV;
          end else begin
            acc_d = acc_new;
            sib_d = sib_inc;
            if (last_sample_i) begin
              state_d = ST_FIN;
            end
          end
        end
      end

      ST_BDIV, ST_FDIVM, ST_FDIVS: begin
        rem_d  = div_ge ? div_diff[REM_W-1:0] : div_shift[REM_W-1:0];
        dq_d   = {dq_q[DQ_W-2:0], div_ge};
        dcnt_d = dcnt_q - DCNT_W'(1);
        if (dcnt_q == DCNT_W'(1)) begin
          priority case (state_q)
            ST_BDIV:  state_d = ST_BSAT;
            ST_FDIVM: state_d = ST_FMEAN;
            default:  state_d = ST_FVAR;
          endcase
        end
      end

      ST_BSAT: begin
        // saturate the block mean to the sample range
        if (!neg_q) begin
          if (quo_short > ACC_W'(MEAN_POS_MAX)) begin
            mag_d = MEAN_POS_MAX;
          end else begin
            mag_d = quo_short[SAMPLE_W-1:0];
          end
          mean_d = mag_d;
        end else begin
          if (quo_short > ACC_W'(MEAN_NEG_MIN)) begin
            mag_d = MEAN_NEG_MIN;
          end else begin
            mag_d = quo_short[SAMPLE_W-1:0];
          end
          mean_d = ~mag_d + SAMPLE_W'(1);
        end
        state_d = ST_BMUL;
      end

      ST_BMUL: begin
        state_d = ST_BACC;
      end

      ST_BACC: begin
        if (cnt_q == CNT_MAX) begin
          ovf_d = 1'b1;
        end else begin
          cnt_d  = cnt_q + CNT_W'(1);
          mtot_d = mtot_q + {{(MTOT_W-SAMPLE_W){mean_q[SAMPLE_W-1]}}, mean_q};
          sq_d   = sq_q + SQ_W'(prod_q);
        end
        state_d = last_q ? ST_FIN : ST_IDLE;
      end

      ST_FIN: begin
        if (cnt_q == '0) begin
          mean_d  = '0;
          var_d   = '0;
          state_d = ST_FOUT;
        end else begin
          dq_d    = {mtot_mag, {(DQ_W-MTOT_W){1'b0}}};
          rem_d   = '0;
          dvs_d   = cnt_q;
          dcnt_d  = DIV_STEPS_SHORT;
          neg_d   = mtot_q[MTOT_W-1];
          state_d = ST_FDIVM;
        end
      end

      ST_FMEAN: begin
        // mean of means, then start on the mean of squares
        mag_d   = quo_short[SAMPLE_W-1:0];
        mean_d  = neg_q ? (~mag_d + SAMPLE_W'(1)) : mag_d;
        dq_d    = sq_q;
        rem_d   = '0;
        dcnt_d  = DIV_STEPS_LONG;
        state_d = ST_FDIVS;
      end

      ST_FVAR: begin
        if (quo_long >= SQ_W'(prod_q)) begin
          var_d = VAR_W'(quo_long - SQ_W'(prod_q));
        end else begin
          var_d = '0;
        end
        state_d = ST_FOUT;
      end

      ST_FOUT: begin
        if (out_load) begin
          acc_d   = '0;
          sib_d   = '0;
          cnt_d   = '0;
          mtot_d  = '0;
          sq_d    = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control and data-set state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_q   <= '0;
      sib_q   <= '0;
      cnt_q   <= '0;
      mtot_q  <= '0;
      sq_q    <= '0;
      ovf_q   <= 1'b0;
      last_q  <= 1'b0;
      dcnt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      sib_q   <= sib_d;
      cnt_q   <= cnt_d;
      mtot_q  <= mtot_d;
      sq_q    <= sq_d;
      ovf_q   <= ovf_d;
      last_q  <= last_d;
      dcnt_q  <= dcnt_d;
      ov_q    <= ov_d;
    end
  end

  // Datapath registers, square of the magnitude registered every cycle
  always_ff @(posedge clk_i) begin
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    neg_q  <= neg_d;
    mean_q <= mean_d;
    mag_q  <= mag_d;
    var_q  <= var_d;
    prod_q <= mag_q * mag_q;
  end

  // Output beat: hold while stalled, load when free
  assign ov_d = out_load || (ov_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_mean_q <= mean_q;
      o_var_q  <= var_q;
      o_full_q <= cnt_q;
      o_drop_q <= sib_q;
      o_none_q <= (cnt_q == '0);
      o_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o      = ov_q;
  assign mean_of_blocks_o = o_mean_q;
  assign block_variance_o = o_var_q;
  assign full_blocks_o    = o_full_q;
  assign dropped_count_o  = o_drop_q;
  assign no_blocks_o      = o_none_q;
  assign count_overflow_o = o_ovf_q;

  // Checks
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && no_blocks_o) |->
      (mean_of_blocks_o == '0 && block_variance_o == '0 && full_blocks_o == '0))
    else $error("no_blocks result carries nonzero statistics");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && count_overflow_o) |-> (full_blocks_o == CNT_MAX))
    else $error("count overflow without saturated block count");

  a_var_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (block_variance_o[VAR_W-1] == 1'b0))
    else $error("variance outside squared sample range");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BACC) |=>
      ((cnt_q == $past(cnt_q) + CNT_W'(1)) || (ovf_q && cnt_q == CNT_MAX)))
    else $error("block count did not advance on a finished block");

endmodule
